### design/i2ctxq_pkg.sv
// Shared constants for the I2C transmit queue sequencer.
// Item kinds, sequencer phases, bus actions, status codes and register indexes.
// No dependencies.
package i2ctxq_pkg;

    // Input item kinds carried in tuser.
    localparam logic [1:0] KIND_PUT  = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_POLL = 2'd2;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_START = 3'd1;
    localparam logic [2:0] PH_START      = 3'd2;
    localparam logic [2:0] PH_ADDRESS    = 3'd3;
    localparam logic [2:0] PH_SEND_DATA  = 3'd4;
    localparam logic [2:0] PH_WAIT_DATA  = 3'd5;

    // Bus actions reported with each result.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_ADDR  = 3'd2;
    localparam logic [2:0] ACT_DATA  = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    // Transfer status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_ADDR = 2'd0;
    localparam logic [1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [1:0] REG_ERR_LIMIT   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_TARGET_ADDR = 8'h7e;
    localparam logic [15:0] RST_TIMEOUT     = 16'd500;
    localparam logic [3:0]  RST_ERR_LIMIT   = 4'd3;

    // Saturation point of the consecutive timeout counter.
    localparam logic [3:0] TMO_CNT_MAX = 4'd15;

endpackage

### design/i2c_tx_queue_sequencer_top.sv
// I2C transmit queue sequencer: byte ring buffer plus master-transmit stepper.
// Depends on i2ctxq_pkg for codes and reset values.
//
// Usage:
//   The s_axis channel takes requests; tuser holds the kind (put, send, poll).
//   A put queues tdata[7:0] into the ring buffer, a send arms a transfer and
//   a poll carries the millisecond clock and the qualified bus flags.
//   Every request produces exactly one result on m_axis, in the cycle after it
//   is accepted. A new request is taken every cycle as long as the output
//   register is empty or being drained, so the sustained rate is one request
//   per cycle; the single read port of the ring buffer memory registers a
//   queued byte as the poll that pops it is accepted.
//   The i_cfg channel writes target address, timeout and error limit; it is
//   always ready and should only be used while no request is in flight.
//   Reset (synchronous, active low) empties the queue, sets the status to
//   done, clears the failure flag and loads the register defaults. The
//   buffer contents are not cleared and no clearing pass is needed.
//   When m_axis_tready is low the pending result holds and s_axis_tready
//   drops until the result is taken.
module i2c_tx_queue_sequencer_top
    import i2ctxq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: data_byte[7:0], now_ms[39:8], bus_free[40], start_sent[41],
    //        address_acked[42], byte_finished[43], zero pad[47:44]
    input  logic [47:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,

    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: bus_action[2:0], bus_byte[10:3], transfer_status[12:11],
    //        byte_accepted[13], failed[14], queued_bytes, peak_elapsed_ms,
    //        zero pad up to a whole byte
    output logic [((47 + $clog2(BUFFER_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,

    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W    = $clog2(BUFFER_DEPTH);
    localparam int CNT_W    = $clog2(BUFFER_DEPTH + 1);
    localparam int OUT_BITS = 47 + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUFFER_DEPTH - 1);

    // Request fields.
    logic [1:0]  w_kind;
    logic [7:0]  w_data_byte;
    logic [31:0] w_now;
    logic        w_bus_free;
    logic        w_start_sent;
    logic        w_addr_acked;
    logic        w_byte_done;

    assign w_kind       = s_axis_tuser;
    assign w_data_byte  = s_axis_tdata[7:0];
    assign w_now        = s_axis_tdata[39:8];
    assign w_bus_free   = s_axis_tdata[40];
    assign w_start_sent = s_axis_tdata[41];
    assign w_addr_acked = s_axis_tdata[42];
    assign w_byte_done  = s_axis_tdata[43];

    // Configuration registers.
    logic [7:0]  r_target_addr;
    logic [15:0] r_timeout;
    logic [3:0]  r_err_limit;

    // Sequencer state.
    logic [2:0]       r_phase,     n_phase;
    logic [IDX_W-1:0] r_wr_idx,    n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx,    n_rd_idx;
    logic [CNT_W-1:0] r_fill,      n_fill;
    logic [31:0]      r_mark,      n_mark;
    logic [31:0]      r_peak,      n_peak;
    logic [3:0]       r_tmo_cnt,   n_tmo_cnt;
    logic [1:0]       r_status,    n_status;
    logic             r_failed,    n_failed;

    // Result register; the state registers above supply the status fields.
    logic             r_out_valid;
    logic [2:0]       r_act,       n_act;
    logic [7:0]       r_byte,      n_byte;
    logic             r_use_mem,   n_use_mem;
    logic             r_accepted,  n_accepted;

    // Ring buffer memory and its registered read data.
    logic [7:0]       r_ring [BUFFER_DEPTH];
    logic [7:0]       r_rd_data;
    logic             w_mem_we;
    logic             w_mem_re;

    logic             w_accept;
    logic [31:0]      w_delta;
    logic             w_tmo_hit;
    logic [IDX_W-1:0] w_rd_idx_inc;
    logic [IDX_W-1:0] w_wr_idx_inc;
    logic [3:0]       w_tmo_cnt_inc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_addr <= RST_TARGET_ADDR;
            r_timeout     <= RST_TIMEOUT;
            r_err_limit   <= RST_ERR_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TARGET_ADDR: r_target_addr <= i_cfg_data[7:0];
                REG_TIMEOUT:     r_timeout     <= i_cfg_data;
                REG_ERR_LIMIT:   r_err_limit   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Elapsed time since the last progress event and the timeout check.
    assign w_delta   = w_now - r_mark;
    assign w_tmo_hit = (r_phase != PH_IDLE) && (w_delta > {16'd0, r_timeout});

    // Ring index increments with wrap at the buffer depth.
    assign w_rd_idx_inc  = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
    assign w_wr_idx_inc  = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
    assign w_tmo_cnt_inc = (r_tmo_cnt == TMO_CNT_MAX) ? r_tmo_cnt : r_tmo_cnt + 4'd1;

    // Next-state logic for one accepted request.
    always_comb begin
        n_phase    = r_phase;
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_fill     = r_fill;
        n_mark     = r_mark;
        n_peak     = r_peak;
        n_tmo_cnt  = r_tmo_cnt;
        n_status   = r_status;
        n_failed   = r_failed;
        n_act      = ACT_NONE;
        n_byte     = 8'd0;
        n_use_mem  = 1'b0;
        n_accepted = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;

        case (w_kind)
            KIND_PUT: begin
                if (r_fill < DEPTH_CNT) begin
                    w_mem_we   = 1'b1;
                    n_wr_idx   = w_wr_idx_inc;
                    n_fill     = r_fill + 1'b1;
                    n_accepted = 1'b1;
                end
            end
            KIND_SEND: begin
                n_mark   = w_now;
                n_phase  = PH_WAIT_START;
                n_status = ST_BUSY;
            end
            KIND_POLL: begin
                if (w_tmo_hit) begin
                    // Abort: stop the bus, drop the queue and count the error.
                    n_wr_idx  = '0;
                    n_rd_idx  = '0;
                    n_fill    = '0;
                    n_phase   = PH_IDLE;
                    n_status  = ST_TIMEOUT;
                    n_tmo_cnt = w_tmo_cnt_inc;
                    n_act     = ACT_STOP;
                    if (w_tmo_cnt_inc > r_err_limit) begin
                        n_failed = 1'b1;
                    end
                end else begin
                    if (r_phase != PH_IDLE) begin
                        n_tmo_cnt = 4'd0;
                        if (w_delta > r_peak) begin
                            n_peak = w_delta;
                        end
                    end
                    case (r_phase)
                        PH_WAIT_START: begin
                            if (w_bus_free) begin
                                n_act   = ACT_START;
                                n_phase = PH_START;
                                n_mark  = w_now;
                            end
                        end
                        PH_START: begin
                            if (w_start_sent) begin
                                n_act   = ACT_ADDR;
                                n_byte  = r_target_addr;
                                n_phase = PH_ADDRESS;
                                n_mark  = w_now;
                            end
                        end
                        PH_ADDRESS: begin
                            if (w_addr_acked) begin
                                n_phase = PH_SEND_DATA;
                            end
                        end
                        PH_SEND_DATA: begin
                            if (r_fill != '0) begin
                                // Pop one byte; the memory returns it next cycle.
                                w_mem_re  = 1'b1;
                                n_use_mem = 1'b1;
                                n_fill    = r_fill - 1'b1;
                                n_rd_idx  = w_rd_idx_inc;
                                n_act     = ACT_DATA;
                                n_mark    = w_now;
                                n_phase   = PH_WAIT_DATA;
                            end else begin
                                n_act    = ACT_STOP;
                                n_status = ST_DONE;
                                n_phase  = PH_IDLE;
                            end
                        end
                        PH_WAIT_DATA: begin
                            if (w_byte_done) begin
                                n_phase = PH_SEND_DATA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // State registers advance on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_fill    <= '0;
            r_mark    <= 32'd0;
            r_peak    <= 32'd0;
            r_tmo_cnt <= 4'd0;
            r_status  <= ST_DONE;
            r_failed  <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_fill    <= n_fill;
            r_mark    <= n_mark;
            r_peak    <= n_peak;
            r_tmo_cnt <= n_tmo_cnt;
            r_status  <= n_status;
            r_failed  <= n_failed;
        end
    end

    // Ring buffer write port.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_mem_we) begin
            r_ring[r_wr_idx] <= w_data_byte;
        end
    end

    // Ring buffer read port with registered data.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_mem_re) begin
            r_rd_data <= r_ring[r_rd_idx];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act      <= n_act;
            r_byte     <= n_byte;
            r_use_mem  <= n_use_mem;
            r_accepted <= n_accepted;
        end
    end

    // Output packing; status fields come straight from the state registers,
    // which only change when the pending result is replaced.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_peak, r_fill, r_failed, r_accepted, r_status,
                                   (r_use_mem ? r_rd_data : r_byte), r_act});

    // Fill count never exceeds the buffer depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_CNT)
        else $error("fill count beyond buffer depth");

    // The failure flag is sticky until reset.
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("failure flag cleared without reset");

    // Busy status and an active phase go together.
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_status != ST_BUSY))
        else $error("status and phase disagree");

    // A data action is only taken with a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mem_re) |-> (r_fill != '0))
        else $error("pop from empty ring buffer");

endmodule

### tb/tb_i2c_tx_queue_sequencer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C transmit queue sequencer top level.
// It drives requests and register writes, predicts every result with a local
// model of the sequencer and compares the results field by field; uses i2ctxq_pkg.
module tb_i2c_tx_queue_sequencer_top
    import i2ctxq_pkg::*;
();

    localparam int DEPTH        = 256;
    localparam int OUT_W        = ((47 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_RUN   = 310;

    // Request kind that the block must ignore, and a register index it must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    // Poll flag masks, ordered {byte_finished, address_acked, start_sent, bus_free}.
    localparam logic [3:0] FLAGS_NONE    = 4'b0000;
    localparam logic [3:0] FLAG_FREE     = 4'b0001;
    localparam logic [3:0] FLAG_START    = 4'b0010;
    localparam logic [3:0] FLAG_ACKED    = 4'b0100;
    localparam logic [3:0] FLAG_FINISHED = 4'b1000;
    localparam logic [3:0] FLAGS_ALL     = 4'b1111;

    typedef struct packed {
        logic [3:0]  pad;
        logic        byte_finished;
        logic        address_acked;
        logic        start_sent;
        logic        bus_free;
        logic [31:0] now_ms;
        logic [7:0]  data_byte;
    } t_request;

    typedef struct packed {
        logic [31:0] peak_elapsed_ms;
        logic [8:0]  queued_bytes;
        logic        failed;
        logic        byte_accepted;
        logic [1:0]  transfer_status;
        logic [7:0]  bus_byte;
        logic [2:0]  bus_action;
    } t_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      s_axis_tdata = '0;
    logic [1:0]       s_axis_tuser = KIND_PUT;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = REG_TARGET_ADDR;
    logic [15:0]      i_cfg_data = '0;

    // Shadow copies of the configuration registers.
    logic [7:0]  cfg_target_addr = RST_TARGET_ADDR;
    logic [15:0] cfg_timeout_ms  = RST_TIMEOUT;
    logic [3:0]  cfg_err_limit   = RST_ERR_LIMIT;

    // Model of the sequencer state.
    logic [2:0]  mdl_phase   = PH_IDLE;
    logic [7:0]  ring_model [0:DEPTH-1];
    logic [7:0]  mdl_wr      = '0;
    logic [7:0]  mdl_rd      = '0;
    logic [8:0]  mdl_fill    = '0;
    logic [31:0] mdl_mark    = '0;
    logic [31:0] mdl_peak    = '0;
    logic [3:0]  mdl_tmo_cnt = '0;
    logic [1:0]  mdl_status  = ST_DONE;
    logic        mdl_failed  = 1'b0;

    t_result     expected_results [$];
    t_result     want_result;
    t_result     got_result;
    logic [31:0] bus_clock_ms  = '0;
    int          requests_sent  = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          sink_stall     = 0;
    int          src_gap_max    = MAX_GAP;
    int          sink_gap_max   = MAX_GAP;

    i2c_tx_queue_sequencer_top #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the sequencer model by one request and return the result it predicts.
    function automatic t_result step_sequencer_model(input logic [1:0] kind,
                                                     input t_request req);
        t_result     res;
        logic [31:0] elapsed;
        logic        aborted;
        res = '0;
        aborted = 1'b0;
        case (kind)
            KIND_PUT: begin
                if (mdl_fill < DEPTH) begin
                    ring_model[mdl_wr] = req.data_byte;
                    mdl_wr = mdl_wr + 8'd1;
                    mdl_fill = mdl_fill + 9'd1;
                    res.byte_accepted = 1'b1;
                end
            end
            KIND_SEND: begin
                mdl_mark = req.now_ms;
                mdl_phase = PH_WAIT_START;
                mdl_status = ST_BUSY;
            end
            KIND_POLL: begin
                // The timeout check runs only while a transfer is active.
                if (mdl_phase != PH_IDLE) begin
                    elapsed = req.now_ms - mdl_mark;
                    if (elapsed > {16'd0, cfg_timeout_ms}) begin
                        mdl_wr = '0;
                        mdl_rd = '0;
                        mdl_fill = '0;
                        mdl_phase = PH_IDLE;
                        mdl_status = ST_TIMEOUT;
                        if (mdl_tmo_cnt < TMO_CNT_MAX)
                            mdl_tmo_cnt = mdl_tmo_cnt + 4'd1;
                        if (mdl_tmo_cnt > cfg_err_limit)
                            mdl_failed = 1'b1;
                        res.bus_action = ACT_STOP;
                        aborted = 1'b1;
                    end else begin
                        mdl_tmo_cnt = '0;
                        if (elapsed > mdl_peak)
                            mdl_peak = elapsed;
                    end
                end
                if (!aborted) begin
                    case (mdl_phase)
                        PH_WAIT_START: begin
                            if (req.bus_free) begin
                                res.bus_action = ACT_START;
                                mdl_phase = PH_START;
                                mdl_mark = req.now_ms;
                            end
                        end
                        PH_START: begin
                            if (req.start_sent) begin
                                res.bus_action = ACT_ADDR;
                                res.bus_byte = cfg_target_addr;
                                mdl_phase = PH_ADDRESS;
                                mdl_mark = req.now_ms;
                            end
                        end
                        PH_ADDRESS: begin
                            if (req.address_acked)
                                mdl_phase = PH_SEND_DATA;
                        end
                        PH_SEND_DATA: begin
                            if (mdl_fill != 0) begin
                                mdl_fill = mdl_fill - 9'd1;
                                res.bus_action = ACT_DATA;
                                res.bus_byte = ring_model[mdl_rd];
                                mdl_rd = mdl_rd + 8'd1;
                                mdl_mark = req.now_ms;
                                mdl_phase = PH_WAIT_DATA;
                            end else begin
                                res.bus_action = ACT_STOP;
                                mdl_status = ST_DONE;
                                mdl_phase = PH_IDLE;
                            end
                        end
                        PH_WAIT_DATA: begin
                            if (req.byte_finished)
                                mdl_phase = PH_SEND_DATA;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        res.transfer_status = mdl_status;
        res.failed = mdl_failed;
        res.queued_bytes = mdl_fill;
        res.peak_elapsed_ms = mdl_peak;
        return res;
    endfunction

    function automatic t_request random_request();
        t_request req;
        req = 48'({$urandom, $urandom});
        req.pad = '0;
        return req;
    endfunction

    function automatic logic [3:0] random_flags();
        logic [3:0] flags;
        for (int i = 0; i < 4; i++)
            flags[i] = ($urandom_range(0, 3) != 0);
        return flags;
    endfunction

    // Send one request after a random gap and record its predicted result.
    task automatic push_request(input logic [1:0] kind, input t_request req);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(step_sequencer_model(kind, req));
        requests_sent++;
    endtask

    task automatic put_byte(input logic [7:0] value);
        t_request req;
        req = random_request();
        req.data_byte = value;
        push_request(KIND_PUT, req);
    endtask

    task automatic arm_send(input logic [31:0] now);
        t_request req;
        req = random_request();
        req.now_ms = now;
        bus_clock_ms = now;
        push_request(KIND_SEND, req);
    endtask

    task automatic poll_bus(input logic [31:0] now, input logic [3:0] flags);
        t_request req;
        req = random_request();
        req.now_ms = now;
        {req.byte_finished, req.address_acked, req.start_sent, req.bus_free} = flags;
        bus_clock_ms = now;
        push_request(KIND_POLL, req);
    endtask

    // Let every outstanding result arrive so the block is idle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            REG_TARGET_ADDR: cfg_target_addr = value[7:0];
            REG_TIMEOUT:     cfg_timeout_ms = value;
            REG_ERR_LIMIT:   cfg_err_limit = value[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One complete transfer with the register defaults, plus ignored requests.
    task automatic test_basic_transfer();
        poll_bus(32'd0, FLAGS_ALL);
        push_request(KIND_UNUSED, random_request());
        put_byte(8'h00);
        put_byte(8'hff);
        arm_send(32'd0);
        poll_bus(32'd10, FLAGS_NONE);
        poll_bus(32'd20, FLAG_FREE);
        poll_bus(32'd30, FLAG_FREE);
        poll_bus(32'd40, FLAG_START);
        poll_bus(32'd50, FLAG_ACKED);
        poll_bus(32'd60, FLAGS_NONE);
        poll_bus(32'd70, FLAG_FINISHED);
        poll_bus(32'd80, FLAGS_ALL);
        poll_bus(32'd90, FLAG_FINISHED);
        poll_bus(32'd100, FLAGS_NONE);
    endtask

    // A send during a transfer restarts it; an empty queue stops right away.
    task automatic test_send_restart();
        arm_send(32'd200);
        poll_bus(32'd210, FLAG_FREE);
        arm_send(32'd220);
        poll_bus(32'd230, FLAG_FREE);
        poll_bus(32'd240, FLAG_START);
        poll_bus(32'd250, FLAG_ACKED);
        poll_bus(32'd260, FLAGS_NONE);
    endtask

    // Fill the queue past its depth, send two bytes, then abort by timeout.
    task automatic test_full_buffer();
        wait_drained();
        write_reg(REG_TIMEOUT, 16'd1000);
        repeat (DEPTH + 3) put_byte(8'($urandom));
        arm_send(32'd5000);
        poll_bus(32'd5001, FLAG_FREE);
        poll_bus(32'd5002, FLAG_START);
        poll_bus(32'd5003, FLAG_ACKED);
        poll_bus(32'd5004, FLAGS_NONE);
        poll_bus(32'd5005, FLAG_FINISHED);
        poll_bus(32'd5006, FLAGS_NONE);
        poll_bus(32'd7000, FLAGS_NONE);
    endtask

    // Timeout at both extremes of the limit, across the wrap of the ms clock.
    task automatic test_timeouts();
        wait_drained();
        write_reg(REG_TARGET_ADDR, 16'h5a00);
        write_reg(REG_TIMEOUT, 16'h0000);
        write_reg(REG_ERR_LIMIT, 16'hfff0);
        arm_send(32'hffff_ffff);
        // No time has passed, so the start goes out.
        poll_bus(32'hffff_ffff, FLAGS_ALL);
        // One ms across the wrap aborts, and a zero error limit fails at once.
        poll_bus(32'h0000_0000, FLAGS_ALL);
        wait_drained();
        write_reg(REG_TIMEOUT, 16'hffff);
        write_reg(REG_ERR_LIMIT, 16'h000f);
        arm_send(32'hffff_8000);
        poll_bus(32'h0000_7fff, FLAG_FREE);
        poll_bus(32'h0001_7fff, FLAGS_ALL);
    endtask

    // Queue some bytes, send, and poll with random flags until the transfer ends or the budget runs out.
    task automatic run_transfer();
        int          byte_total;
        int          budget;
        logic [31:0] step_ms;
        src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        byte_total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 5);
        repeat (byte_total) put_byte(8'($urandom));
        arm_send(bus_clock_ms + $urandom_range(0, 3));
        budget = 4 * byte_total + 12;
        while (mdl_phase != PH_IDLE && budget > 0) begin
            budget--;
            if ($urandom_range(0, 39) == 0) begin
                // A stray put or send in the middle of the transfer.
                if ($urandom_range(0, 1) == 0)
                    put_byte(8'($urandom));
                else
                    arm_send(bus_clock_ms);
            end else begin
                if ($urandom_range(0, 24) == 0)
                    step_ms = cfg_timeout_ms + 1 + $urandom_range(0, 15);
                else
                    step_ms = $urandom_range(0, cfg_timeout_ms);
                poll_bus(bus_clock_ms + step_ms, random_flags());
            end
        end
    endtask

    // Random traffic under one register setting: mostly transfers, some noise.
    task automatic test_random_traffic(input logic [7:0] addr, input logic [15:0] tmo,
                                       input logic [3:0] lim, input int count);
        int goal;
        wait_drained();
        write_reg(REG_TARGET_ADDR, {8'($urandom), addr});
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_ERR_LIMIT, {12'($urandom), lim});
        write_reg(REG_UNUSED, 16'($urandom));
        bus_clock_ms = $urandom;
        goal = requests_sent + count;
        while (requests_sent < goal) begin
            if ($urandom_range(0, 9) == 0)
                push_request(2'($urandom_range(0, 3)), random_request());
            else
                run_transfer();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result = t_result'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                $error("result %h arrived with no request outstanding", m_axis_tdata);
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                check_field("bus_action", want_result.bus_action, got_result.bus_action);
                check_field("bus_byte", want_result.bus_byte, got_result.bus_byte);
                check_field("transfer_status", want_result.transfer_status,
                            got_result.transfer_status);
                check_field("byte_accepted", want_result.byte_accepted,
                            got_result.byte_accepted);
                check_field("failed", want_result.failed, got_result.failed);
                check_field("queued_bytes", want_result.queued_bytes,
                            got_result.queued_bytes);
                check_field("peak_elapsed_ms", want_result.peak_elapsed_ms,
                            got_result.peak_elapsed_ms);
            end
        end
    end

    // Result side: stall for a random number of cycles after each result.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sink_stall = $urandom_range(0, sink_gap_max);
        else if (sink_stall > 0)
            sink_stall--;
        m_axis_tready <= (sink_stall == 0);
    end

    // End the run if no channel moves anything for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_transfer();
        test_send_restart();
        test_full_buffer();
        test_random_traffic(8'hff, 16'hffff, 4'hf, RANDOM_RUN);
        test_random_traffic(8'($urandom), 16'($urandom_range(1, 2000)),
                            4'($urandom), RANDOM_RUN);
        test_random_traffic(8'($urandom), 16'd20, 4'($urandom), RANDOM_RUN);
        test_random_traffic(RST_TARGET_ADDR, RST_TIMEOUT, RST_ERR_LIMIT, RANDOM_RUN);
        test_timeouts();
        test_random_traffic(8'h00, 16'h0000, 4'h0, RANDOM_RUN);
        wait_drained();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/i2ctxq_pkg.sv
design/i2c_tx_queue_sequencer_top.sv
tb/tb_i2c_tx_queue_sequencer_top.sv
